### sv/assert_macros.svh
// Assertion helpers, sampled on clk and disabled during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

### sv/ptfa_pkg.sv
package ptfa_pkg;

  localparam int DEFAULT_NUM_FRAMES        = 10;
  localparam int DEFAULT_NUM_PROCESSES     = 2;
  localparam int DEFAULT_PAGES_PER_PROCESS = 16;

  localparam int PID_W    = 1;
  localparam int PAGE_W   = 4;
  localparam int STATUS_W = 2;
  localparam int FRAME_W  = 4;

  localparam logic [STATUS_W-1:0] STATUS_RESIDENT  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ALLOCATED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic out_hold;
  } sts_t;

endpackage

### sv/page_table_frame_allocator.sv
// Page table with lowest-free frame allocation.
// Input channel (in_valid/in_ready): one page access per transaction,
//   process_id and page_number.
// Output channel (out_valid/out_ready): one result per access, status
//   (0 resident, 1 newly allocated, 2 full or out of range) and frame_number.
// An accepted access has its slot, range check and table read registered;
//   in lookup the hit check, frame pick and write-back happen together and
//   the result enters the output register. No new access is taken until then.
// in_ready is high whenever no access is in lookup, also while a result
//   still waits in the output register.
// When the receiver stalls, the result holds in the output register and a
//   lookup in progress waits for it to drain; then input stalls too.
// Reset (rst, synchronous) clears all mapping valid bits and the frame
//   allocation count and empties the output register; no clearing pass.
// Frames are never released, so once all are used every miss reports full.
`include "assert_macros.svh"

module page_table_frame_allocator #(
  parameter int NUM_FRAMES        = ptfa_pkg::DEFAULT_NUM_FRAMES,
  parameter int NUM_PROCESSES     = ptfa_pkg::DEFAULT_NUM_PROCESSES,
  parameter int PAGES_PER_PROCESS = ptfa_pkg::DEFAULT_PAGES_PER_PROCESS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ptfa_pkg::PID_W-1:0]    process_id,
  input  logic [ptfa_pkg::PAGE_W-1:0]   page_number,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ptfa_pkg::STATUS_W-1:0] status,
  output logic [ptfa_pkg::FRAME_W-1:0]  frame_number
);

  ptfa_pkg::cmd_t cmd;
  ptfa_pkg::sts_t sts;

  ptfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ptfa_datapath #(
    .NUM_FRAMES        (NUM_FRAMES),
    .NUM_PROCESSES     (NUM_PROCESSES),
    .PAGES_PER_PROCESS (PAGES_PER_PROCESS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .process_id   (process_id),
    .page_number  (page_number),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .frame_number (frame_number)
  );

  `ASSERT_CLK(a_commit_has_room, cmd.commit |-> !(out_valid && !out_ready), "commit into stalled output")
  `ASSERT_NEVER(a_capture_commit_excl, cmd.capture && cmd.commit, "capture and commit together")
  `ASSERT_CLK(a_out_from_commit, $rose(out_valid) |-> $past(cmd.commit), "result without commit")
  `ASSERT_CLK(a_full_zero_frame, (out_valid && status == ptfa_pkg::STATUS_FULL) |-> frame_number == '0, "full result with frame")

endmodule

### sv/ptfa_ctrl.sv
module ptfa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  ptfa_pkg::sts_t sts,
  output ptfa_pkg::cmd_t cmd
);

  ptfa_pkg::state_t state;
  ptfa_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ptfa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ptfa_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = ptfa_pkg::ST_LOOKUP;
        end
      end
      ptfa_pkg::ST_LOOKUP: begin
        if (!sts.out_hold) begin
          state_next = ptfa_pkg::ST_IDLE;
        end
      end
      default: state_next = ptfa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    unique case (state)
      ptfa_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ptfa_pkg::ST_LOOKUP: begin
        cmd.commit = !sts.out_hold;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

### sv/ptfa_datapath.sv
module ptfa_datapath #(
  parameter int NUM_FRAMES        = ptfa_pkg::DEFAULT_NUM_FRAMES,
  parameter int NUM_PROCESSES     = ptfa_pkg::DEFAULT_NUM_PROCESSES,
  parameter int PAGES_PER_PROCESS = ptfa_pkg::DEFAULT_PAGES_PER_PROCESS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ptfa_pkg::cmd_t                cmd,
  output ptfa_pkg::sts_t                sts,
  input  logic [ptfa_pkg::PID_W-1:0]    process_id,
  input  logic [ptfa_pkg::PAGE_W-1:0]   page_number,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ptfa_pkg::STATUS_W-1:0] status,
  output logic [ptfa_pkg::FRAME_W-1:0]  frame_number
);

  // Only ids and pages that fit the input fields can ever be addressed.
  localparam int PID_SPAN  = 2 ** ptfa_pkg::PID_W;
  localparam int PAGE_SPAN = 2 ** ptfa_pkg::PAGE_W;
  localparam int EFF_PROCS = (NUM_PROCESSES < PID_SPAN) ? NUM_PROCESSES : PID_SPAN;
  localparam int EFF_PAGES = (PAGES_PER_PROCESS < PAGE_SPAN) ? PAGES_PER_PROCESS : PAGE_SPAN;
  localparam int DEPTH     = EFF_PROCS * EFF_PAGES;
  localparam int SLOT_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(NUM_FRAMES + 1);

  logic [DEPTH-1:0]                  valid_bits;
  logic [ptfa_pkg::FRAME_W-1:0]      frame_mem [DEPTH];
  logic [ptfa_pkg::FRAME_W-1:0]      rd_frame;
  logic [SLOT_W-1:0]                 slot;
  logic                              range_ok;
  logic [31:0]                       slot_wide;
  logic                              in_range;
  // Frames are taken lowest first and never freed: used frames form a prefix.
  logic [CNT_W-1:0]                  alloc_cnt;
  logic                              hit;
  logic                              mem_full;
  logic                              do_alloc;
  logic [ptfa_pkg::FRAME_W-1:0]      new_frame;
  logic [ptfa_pkg::STATUS_W-1:0]     status_next;
  logic [ptfa_pkg::FRAME_W-1:0]      frame_number_next;

  assign in_range  = (32'(process_id) < 32'(NUM_PROCESSES)) &&
                     (32'(page_number) < 32'(PAGES_PER_PROCESS));
  assign slot_wide = 32'(process_id) * 32'(EFF_PAGES) + 32'(page_number);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      slot     <= slot_wide[SLOT_W-1:0];
      range_ok <= in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd_frame <= frame_mem[slot_wide[SLOT_W-1:0]];
    end
    if (cmd.commit && do_alloc) begin
      frame_mem[slot] <= new_frame;
    end
  end

  assign hit       = range_ok && valid_bits[slot];
  assign mem_full  = (alloc_cnt == CNT_W'(NUM_FRAMES));
  assign do_alloc  = range_ok && !hit && !mem_full;
  assign new_frame = ptfa_pkg::FRAME_W'(alloc_cnt);

  always_comb begin
    priority if (!range_ok) begin
      status_next       = ptfa_pkg::STATUS_FULL;
      frame_number_next = '0;
    end else if (hit) begin
      status_next       = ptfa_pkg::STATUS_RESIDENT;
      frame_number_next = rd_frame;
    end else if (mem_full) begin
      status_next       = ptfa_pkg::STATUS_FULL;
      frame_number_next = '0;
    end else begin
      status_next       = ptfa_pkg::STATUS_ALLOCATED;
      frame_number_next = new_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      alloc_cnt  <= '0;
    end else if (cmd.commit && do_alloc) begin
      valid_bits[slot] <= 1'b1;
      alloc_cnt        <= alloc_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status       <= status_next;
      frame_number <= frame_number_next;
    end
  end

  assign sts.out_hold = out_valid && !out_ready;

endmodule

### verif/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_FRAMES        = ptfa_pkg::DEFAULT_NUM_FRAMES;
  localparam int NUM_PROCESSES     = ptfa_pkg::DEFAULT_NUM_PROCESSES;
  localparam int PAGES_PER_PROCESS = ptfa_pkg::DEFAULT_PAGES_PER_PROCESS;
  localparam int TABLE_DEPTH       = NUM_PROCESSES * PAGES_PER_PROCESS;
  localparam int RANDOM_ACCESSES   = 1600;
  localparam int IDLE_LIMIT        = 2000;

  typedef struct packed {
    logic [ptfa_pkg::STATUS_W-1:0] status;
    logic [ptfa_pkg::FRAME_W-1:0]  frame;
  } translation_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [ptfa_pkg::PID_W-1:0]    process_id = '0;
  logic [ptfa_pkg::PAGE_W-1:0]   page_number = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [ptfa_pkg::STATUS_W-1:0] status;
  logic [ptfa_pkg::FRAME_W-1:0]  frame_number;

  // predictor state
  logic                         page_resident [TABLE_DEPTH];
  logic [ptfa_pkg::FRAME_W-1:0] page_frame [TABLE_DEPTH];
  logic                         frame_taken [NUM_FRAMES];

  translation_t pending_translations[$];
  int unsigned  mismatch_count = 0;
  int unsigned  burst_left = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  cycle_count = 0;
  int unsigned  ready_mode = 0;

  page_table_frame_allocator dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .process_id   (process_id),
    .page_number  (page_number),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .frame_number (frame_number)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic translation_t translate_access(int unsigned pid, int unsigned page);
    translation_t r;
    int unsigned  slot;
    int           free_frame;
    r.status = ptfa_pkg::STATUS_FULL;
    r.frame  = '0;
    free_frame = -1;
    if (pid >= NUM_PROCESSES || page >= PAGES_PER_PROCESS) begin
      return r;
    end
    slot = pid * PAGES_PER_PROCESS + page;
    if (page_resident[slot]) begin
      r.status = ptfa_pkg::STATUS_RESIDENT;
      r.frame  = page_frame[slot];
      return r;
    end
    for (int f = NUM_FRAMES - 1; f >= 0; f--) begin
      if (!frame_taken[f]) free_frame = f;
    end
    if (free_frame < 0) begin
      return r;
    end
    frame_taken[free_frame] = 1'b1;
    page_resident[slot]     = 1'b1;
    page_frame[slot]        = free_frame[ptfa_pkg::FRAME_W-1:0];
    r.status = ptfa_pkg::STATUS_ALLOCATED;
    r.frame  = free_frame[ptfa_pkg::FRAME_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  // one access transaction; bursts of random length with random gaps between them
  task automatic send_access(input int unsigned pid, input int unsigned page);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    process_id  <= pid[ptfa_pkg::PID_W-1:0];
    page_number <= page[ptfa_pkg::PAGE_W-1:0];
    in_valid    <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_translations.push_back(translate_access(pid, page));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_translations.size() != 0);
  endtask

  // frames are handed out lowest first, across processes and at page extremes
  task automatic test_allocation_order();
    send_access(0, 0);
    send_access(1, 15);
    send_access(0, 15);
    send_access(1, 0);
  endtask

  task automatic test_resident_hits();
    send_access(0, 0);
    send_access(1, 15);
    send_access(0, 15);
    send_access(1, 0);
    send_access(1, 0);
  endtask

  // use the remaining frames, then misses must report full while hits still work
  task automatic test_memory_full();
    send_access(0, 5);
    send_access(1, 10);
    send_access(0, 10);
    send_access(1, 5);
    send_access(0, 3);
    send_access(1, 12);
    send_access(0, 1);
    send_access(1, 1);
    send_access(0, 14);
    send_access(1, 12);
    send_access(0, 5);
    send_access(1, 14);
  endtask

  task automatic test_random_accesses();
    for (int i = 0; i < RANDOM_ACCESSES; i++) begin
      if (i % 400 == 399) drain_results();
      send_access($urandom_range(0, NUM_PROCESSES - 1), $urandom_range(0, 15));
    end
  endtask

  // receiver stall pattern, switching between randomly chosen modes
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 128 == 0) ready_mode <= $urandom_range(0, 3);
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= (cycle_count % 4 == 0);
      default: out_ready <= (cycle_count % 32 >= 12);
    endcase
  end

  always @(posedge clk) begin
    translation_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_translations.size() == 0) begin
        report_mismatch($sformatf("unexpected result status %0d frame %0d",
                                  status, frame_number));
      end else begin
        want = pending_translations.pop_front();
        if (status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
        if (frame_number !== want.frame)
          report_mismatch($sformatf("frame %0d, expected %0d", frame_number, want.frame));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      page_resident[i] = 1'b0;
      page_frame[i]    = '0;
    end
    for (int i = 0; i < NUM_FRAMES; i++) frame_taken[i] = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_allocation_order();
    test_resident_hits();
    test_memory_full();
    test_random_accesses();
    drain_results();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/ptfa_pkg.sv
sv/ptfa_ctrl.sv
sv/ptfa_datapath.sv
sv/page_table_frame_allocator.sv
verif/testbench.sv
